### design/response_frame_checker_unit_macros.svh
// ----------------------------------------------------------------------------
// response frame checker assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef RESPONSE_FRAME_CHECKER_UNIT_MACROS_SVH
`define RESPONSE_FRAME_CHECKER_UNIT_MACROS_SVH

// same-cycle implication
`define RFC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("rfc assertion failed");

// next-cycle implication
`define RFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("rfc assertion failed");

`endif

### design/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// constants, status codes and crc-16 helpers for the response frame checker
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

    localparam int MAX_FRAME_BYTES = 4096;
    // count must hold max_frame_bytes itself
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
    localparam int LEN_W           = 16;
    // length plus overhead, one bit wider than the length
    localparam int LSUM_W          = LEN_W + 1;
    localparam logic [LSUM_W-1:0] FRAME_OVERHEAD = LSUM_W'(9);

    localparam int POS_SEQ   = 2;
    localparam int POS_LEN_L = 5;
    localparam int POS_LEN_H = 6;

    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_GOOD       = 2'd1,
        ST_CRC_ERR    = 2'd2,
        ST_OVERFLOW   = 2'd3
    } t_status;

    // crc-16 poly 0x1021 nibble table
    localparam logic [15:0] NIB_TAB [16] = '{
        16'h0000, 16'h1021, 16'h2042, 16'h3063,
        16'h4084, 16'h50a5, 16'h60c6, 16'h70e7,
        16'h8108, 16'h9129, 16'ha14a, 16'hb16b,
        16'hc18c, 16'hd1ad, 16'he1ce, 16'hf1ef
    };

    function automatic logic [15:0] crc_nibble(input logic [15:0] crc,
                                               input logic [3:0]  nib);
        logic [3:0] idx;
        idx = crc[15:12] ^ nib;
        return {crc[11:0], 4'h0} ^ NIB_TAB[idx];
    endfunction

    // high nibble first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [7:0]  b);
        logic [15:0] mid;
        mid = crc_nibble(crc, b[7:4]);
        return crc_nibble(mid, b[3:0]);
    endfunction

endpackage

`default_nettype wire

### design/rfc_ifs.sv
// ----------------------------------------------------------------------------
// rfc stream interfaces
// valid/ready channels for received bytes and frame verdicts
// ----------------------------------------------------------------------------
`default_nettype none

interface rfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  seq_id;
    logic [15:0] payload_length;

    modport source (output valid, output status, output seq_id,
                    output payload_length, input ready);
    modport sink   (input valid, input status, input seq_id,
                    input payload_length, output ready);
endinterface

`default_nettype wire

### design/response_frame_checker_unit.sv
// path: a taken beat is registered in the byte register, then in the result register
// throughput: one byte per cycle unless the result side stalls; the crc step is two
// nibble-table lookups between the byte register and the result register
// back-pressure: a waiting result stalls the byte register, never the channel early
// reset: synchronous, active low; clears frame state and both valid flags
// ----------------------------------------------------------------------------
// response frame checker unit
// counts response bytes, captures sequence and length, runs crc-16 xmodem
// over all but the last two bytes and reports one verdict beat per byte
// ----------------------------------------------------------------------------
`default_nettype none

module response_frame_checker_unit (
    input  wire  i_clk,
    input  wire  i_rst_n,
    rfc_in_if.sink    i_rx,
    rfc_out_if.source o_res
);
    import rfc_pkg::*;

    // byte register stage
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;

    // result register stage
    logic              r_out_valid;
    t_status           r_status;
    logic [7:0]        r_seq;
    logic [LEN_W-1:0]  r_len;

    // frame state
    logic [CNT_W-1:0]  r_count;
    logic [LEN_W-1:0]  r_cap_len;
    logic [7:0]        r_cap_seq;
    logic [15:0]       r_crc;
    logic [7:0]        r_d0;   // newest byte
    logic [7:0]        r_d1;   // older byte

    logic              s1_move;
    logic              in_fire;
    logic              s1_fire;

    logic [CNT_W-1:0]  n_count;
    logic [LEN_W-1:0]  n_cap_len;
    logic [7:0]        n_cap_seq;
    logic [15:0]       n_crc;
    logic              done;
    logic              length_hit;
    logic              crc_ok;
    t_status           verdict;

    // result register frees when empty or being taken
    assign s1_move    = !r_out_valid || o_res.ready;
    assign i_rx.ready = !r_s1_valid || s1_move;
    assign in_fire    = i_rx.valid && i_rx.ready;
    assign s1_fire    = r_s1_valid && s1_move;

    // per-byte update, all from the byte register and frame state
    always_comb begin
        n_crc     = r_crc;
        n_cap_seq = r_cap_seq;
        n_cap_len = r_cap_len;

        // crc trails the stream by two bytes
        if (r_count >= CNT_W'(POS_SEQ)) begin
            n_crc = crc_byte(r_crc, r_d1);
        end

        if (r_count == CNT_W'(POS_SEQ)) begin
            n_cap_seq = r_s1_byte;
        end else if (r_count == CNT_W'(POS_LEN_L)) begin
            n_cap_len = {r_cap_len[15:8], r_s1_byte};
        end else if (r_count == CNT_W'(POS_LEN_H)) begin
            n_cap_len = {r_s1_byte, r_cap_len[7:0]};
        end

        n_count    = r_count + CNT_W'(1);
        length_hit = (LSUM_W'(n_count) == (LSUM_W'(n_cap_len) + FRAME_OVERHEAD));
        // crc low byte came first, high byte is the current one
        crc_ok     = (n_crc[7:0] == r_d0) && (n_crc[15:8] == r_s1_byte);

        if (length_hit) begin
            verdict = crc_ok ? ST_GOOD : ST_CRC_ERR;
            done    = 1'b1;
        end else if (n_count >= CNT_W'(MAX_FRAME_BYTES)) begin
            verdict = ST_OVERFLOW;
            done    = 1'b1;
        end else begin
            verdict = ST_INCOMPLETE;
            done    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_s1_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // result payload, zero fields while the frame is incomplete
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_status <= verdict;
            r_seq    <= done ? n_cap_seq : 8'h00;
            r_len    <= done ? n_cap_len : '0;
        end
    end

    // frame state advances once per byte moving into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cap_len <= '0;
            r_cap_seq <= 8'h00;
            r_crc     <= 16'h0000;
            r_d0      <= 8'h00;
            r_d1      <= 8'h00;
        end else if (s1_fire) begin
            if (done) begin
                r_count   <= '0;
                r_cap_len <= '0;
                r_cap_seq <= 8'h00;
                r_crc     <= 16'h0000;
                r_d0      <= 8'h00;
                r_d1      <= 8'h00;
            end else begin
                r_count   <= n_count;
                r_cap_len <= n_cap_len;
                r_cap_seq <= n_cap_seq;
                r_crc     <= n_crc;
                r_d0      <= r_s1_byte;
                r_d1      <= r_d0;
            end
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_status;
    assign o_res.seq_id         = r_seq;
    assign o_res.payload_length = r_len;

`include "response_frame_checker_unit_macros.svh"

    // a verdict leaves the frame state cleared
    `RFC_ASSERT_NEXT(a_clear_after_verdict, s1_fire && done,
                     r_count == '0 && r_crc == 16'h0000)

    // the count never sits at the overflow limit
    `RFC_ASSERT_IMPL(a_count_bound, 1'b1, r_count < CNT_W'(MAX_FRAME_BYTES))

    // incomplete beats carry zero fields
    `RFC_ASSERT_IMPL(a_incomplete_zero, r_out_valid && r_status == ST_INCOMPLETE,
                     r_seq == 8'h00 && r_len == '0)

    // a stalled byte stays in the byte register
    `RFC_ASSERT_NEXT(a_s1_hold, r_s1_valid && !s1_move, r_s1_valid && $stable(r_s1_byte))

    // frame state only moves when a byte is retired
    `RFC_ASSERT_NEXT(a_state_quiet, !s1_fire, $stable(r_count) && $stable(r_crc))

endmodule

`default_nettype wire

### sim/response_frame_checker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response frame checker unit testbench
// streams response frames byte by byte into the checker, predicts every
// verdict beat with an independent bitwise crc-16 model and compares each
// result beat in order, under random gaps and long receiver hold-offs
// ----------------------------------------------------------------------------

module response_frame_checker_unit_tb;

    import rfc_pkg::*;

    // one result beat, as the checker reports it
    typedef struct packed {
        t_status     status;
        logic [7:0]  seq_id;
        logic [15:0] payload_length;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rfc_in_if  rx_bytes_if ();
    rfc_out_if verdict_if ();

    response_frame_checker_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_bytes_if),
        .o_res   (verdict_if)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // frame tracking state of the predictor, all clear after reset
    // ------------------------------------------------------------------------
    int          frame_pos = 0;       // bytes taken so far in this frame
    logic [15:0] held_len  = '0;      // length from bytes 5 and 6
    logic [7:0]  held_seq  = '0;      // byte 2 of the frame
    logic [15:0] crc_acc   = '0;      // crc over all but the two newest bytes
    logic [7:0]  last_byte = '0;      // newest byte
    logic [7:0]  prev_byte = '0;      // the one before it

    t_verdict pending_verdicts[$];

    // idling controls, shared by the tests and the two sides
    bit tx_gaps       = 1'b0;
    bit rx_gaps       = 1'b0;
    int stall_request = 0;
    int hold_left     = 0;

    int errors      = 0;
    int bytes_sent  = 0;
    int beats_seen  = 0;
    int n_good      = 0;
    int n_crc_err   = 0;
    int n_overflow  = 0;

    // crc-16 xmodem, bit at a time, msb first
    function automatic logic [15:0] crc16_xmodem_step(input logic [15:0] crc,
                                                      input logic [7:0]  value);
        logic [15:0] r;
        r = crc ^ {value, 8'h00};
        for (int k = 0; k < 8; k++)
            r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
        return r;
    endfunction

    // advance the frame tracker by one byte and give the verdict beat it causes
    function automatic t_verdict next_verdict(input logic [7:0] value);
        t_verdict v;
        int       count;
        v = '{ST_INCOMPLETE, 8'h00, 16'h0000};
        // the byte two places back is now known not to be part of the crc field
        if (frame_pos >= 2)
            crc_acc = crc16_xmodem_step(crc_acc, prev_byte);
        case (frame_pos)
            POS_SEQ:   held_seq = value;
            POS_LEN_L: held_len[7:0] = value;
            POS_LEN_H: held_len[15:8] = value;
            default: ;
        endcase
        count = frame_pos + 1;
        // a frame that completes right at the size limit still gets its verdict
        if (count == int'(held_len) + int'(FRAME_OVERHEAD)) begin
            v.status = (crc_acc[7:0] == last_byte && crc_acc[15:8] == value) ?
                       ST_GOOD : ST_CRC_ERR;
        end else if (count >= MAX_FRAME_BYTES) begin
            v.status = ST_OVERFLOW;
        end
        if (v.status != ST_INCOMPLETE) begin
            v.seq_id         = held_seq;
            v.payload_length = held_len;
            frame_pos = 0;
            held_len  = '0;
            held_seq  = '0;
            crc_acc   = '0;
            last_byte = '0;
            prev_byte = '0;
        end else begin
            prev_byte = last_byte;
            last_byte = value;
            frame_pos = count;
        end
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // sender: called at a falling edge, returns at the falling edge after the
    // beat was taken; valid stays high so back-to-back beats need no gap
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value);
        while (tx_gaps && $urandom_range(99) < 9) begin
            rx_bytes_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_bytes_if.valid   <= 1'b1;
        rx_bytes_if.rx_byte <= value;
        do @(posedge i_clk); while (!rx_bytes_if.ready);
        pending_verdicts.push_back(next_verdict(value));
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // sender goes quiet until every predicted beat has come back
    task automatic pause_sender();
        rx_bytes_if.valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge i_clk);
    endtask

    // well-formed frame with a correct crc, optionally with one byte spoilt;
    // fill below zero means random header and payload bytes
    task automatic send_frame(input logic [7:0] seq, input logic [15:0] len,
                              input int fill, input int flip_at,
                              input logic [7:0] flip_mask);
        logic [7:0]  frame_bytes[$];
        logic [15:0] crc;
        logic [7:0]  value;
        crc = 16'h0000;
        for (int n = 0; n < int'(len) + 7; n++) begin
            case (n)
                POS_SEQ:   value = seq;
                POS_LEN_L: value = len[7:0];
                POS_LEN_H: value = len[15:8];
                default:   value = (fill < 0) ? 8'($urandom) : 8'(fill);
            endcase
            frame_bytes.push_back(value);
            crc = crc16_xmodem_step(crc, value);
        end
        // crc goes out low byte first
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
        if (flip_at >= 0)
            frame_bytes[flip_at] ^= flip_mask;
        foreach (frame_bytes[n])
            send_byte(frame_bytes[n]);
    endtask

    // random bytes with a forced length field, until the checker closes the frame
    task automatic send_until_done(input logic [15:0] len);
        logic [7:0] value;
        do begin
            case (frame_pos)
                POS_LEN_L: value = len[7:0];
                POS_LEN_H: value = len[15:8];
                default:   value = 8'($urandom);
            endcase
            send_byte(value);
        end while (frame_pos != 0);
    endtask

    // random frame: mostly short, now and then longer
    task automatic send_random_frame();
        logic [15:0] len;
        int          pick;
        int          flip_at;
        pick = $urandom_range(99);
        if (pick < 85)
            len = 16'($urandom_range(24));
        else if (pick < 95)
            len = 16'($urandom_range(120, 25));
        else
            len = 16'($urandom_range(300, 121));
        pick = $urandom_range(99);
        if (pick < 75) begin
            send_frame(8'($urandom), len, -1, -1, 8'h00);
        end else if (pick < 92) begin
            // one flipped bit anywhere but the length field
            flip_at = $urandom_range(int'(len) + 8);
            if (flip_at == POS_LEN_L || flip_at == POS_LEN_H)
                flip_at = int'(len) + 8;
            send_frame(8'($urandom), len, -1, flip_at, 8'(1 << $urandom_range(7)));
        end else begin
            // line noise with a short length so that it closes soon
            send_until_done({8'h00, 8'($urandom)});
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver: ready changes at the falling edge; a requested hold-off is
    // counted down here, cycle by cycle
    // ------------------------------------------------------------------------
    initial begin
        verdict_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_request > 0) begin
                hold_left     = stall_request;
                stall_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                verdict_if.ready <= 1'b0;
            end else begin
                verdict_if.ready <= !(rx_gaps && $urandom_range(99) < 9);
            end
        end
    end

    // ------------------------------------------------------------------------
    // checker: every result beat against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && verdict_if.valid && verdict_if.ready) begin
            beats_seen++;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected beat, status %0d seq %02h length %0d",
                         $time, verdict_if.status, verdict_if.seq_id,
                         verdict_if.payload_length);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                case (want.status)
                    ST_GOOD:     n_good++;
                    ST_CRC_ERR:  n_crc_err++;
                    ST_OVERFLOW: n_overflow++;
                    default: ;
                endcase
                if (verdict_if.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, verdict_if.status);
                    errors++;
                end
                if (verdict_if.seq_id !== want.seq_id) begin
                    $display("%0t: seq_id expected %02h actual %02h",
                             $time, want.seq_id, verdict_if.seq_id);
                    errors++;
                end
                if (verdict_if.payload_length !== want.payload_length) begin
                    $display("%0t: payload_length expected %0d actual %0d",
                             $time, want.payload_length, verdict_if.payload_length);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // all-zero frame with no payload, then an all-ones frame with a bad crc
    // low byte; the first eight bytes must never look complete
    task automatic test_directed();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        send_frame(8'h00, 16'd0, 8'h00, -1, 8'h00);
        send_frame(8'hff, 16'd1, 8'hff, 1 + 7, 8'h01);
        pause_sender();
    endtask

    // random frames with both sides idling now and then
    task automatic test_random_traffic(input int target);
        int stop_at;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at)
            send_random_frame();
        pause_sender();
    endtask

    // long stretch at full rate, no idling on either side
    task automatic test_steady_stream(input int target);
        int stop_at;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at)
            send_random_frame();
        pause_sender();
    endtask

    // receiver holds off while the sender keeps offering, so the pipeline
    // fills and the input stalls; once without and once with idling
    task automatic test_backpressure();
        int stop_at;
        for (int round = 0; round < 2; round++) begin
            tx_gaps = round[0];
            rx_gaps = round[0];
            stall_request = 250;
            stop_at = bytes_sent + 120;
            while (bytes_sent < stop_at)
                send_random_frame();
            pause_sender();
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n             <= 1'b0;
        rx_bytes_if.valid   <= 1'b0;
        rx_bytes_if.rx_byte <= 8'h00;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_traffic(1100);
        test_backpressure();
        test_steady_stream(300);
        test_random_traffic(60);

        pause_sender();
        // let any stray beat surface before the verdict
        repeat (8) @(posedge i_clk);
        $display("covered %0d bytes and %0d result beats", bytes_sent, beats_seen);
        $display("%0d good frames, %0d crc mismatches, %0d overflows",
                 n_good, n_crc_err, n_overflow);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/rfc_pkg.sv
design/rfc_ifs.sv
design/response_frame_checker_unit.sv
sim/response_frame_checker_unit_tb.sv
